### rtl/ppdr_pkg.sv
// Shared types, widths and constants for the planar pose dead-reckoning block.
// Holds the sequencer state and operand-select enums, the CORDIC result struct
// and the arctangent table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ppdr_pkg;

    localparam int VEL_W      = 16;
    localparam int DT_W       = 20;
    localparam int POS_W      = 48;
    localparam int HEAD_W     = 32;
    localparam int SUM_W      = POS_W + 1;
    localparam int CORD_W     = 34;
    localparam int TRIG_W     = 26;
    localparam int ROUND_SH   = 6;
    localparam int MUL_A_W    = 18;
    localparam int MUL_B_W    = 26;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int MAG_W      = 2 * MUL_A_W;
    localparam int ACC_W      = 62;
    localparam int POS_FRAC   = 24;
    localparam int DVD_W      = 34;
    localparam int RCP_SH     = 2;
    localparam int RCP_FRAC   = 34;
    localparam int DIV_Q_W    = 22;
    localparam int ANG_FRAC   = 28;
    localparam int ATAN_IDX_W = 5;

    localparam int CORDIC_STEPS_DEF = 24;

    localparam logic signed [CORD_W-1:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic signed [CORD_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [CORD_W-1:0] HALF_TURN    = 34'sd2147483648;

    // 62500 = 4 * 15625; reciprocal is floor(2^34 / 15625)
    localparam logic [ACC_W-1:0] POS_HALF  = ACC_W'(64'd31250 << POS_FRAC);
    localparam logic [MUL_A_W-1:0] DIV_D   = 18'd15625;
    localparam logic [MUL_B_W-1:0] DIV_RCP = 26'd1099511;
    localparam logic [MUL_B_W-1:0] ANG_SCALE = 26'd44798134;
    localparam logic [ACC_W-1:0] ANG_HALF  = ACC_W'(64'd1 << (ANG_FRAC - 1));

    localparam logic signed [SUM_W-1:0] POS_MAX_EXT = {2'b00, {(POS_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] POS_MIN_EXT = {2'b11, {(POS_W - 1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_T,
        S_MUL_P,
        S_TRIG,
        S_MUL_LO,
        S_MUL_HI,
        S_DIV_INIT,
        S_RCP_LO,
        S_RCP_HI,
        S_RCP_FIX,
        S_POS_UPD,
        S_HEAD_UPD,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        OP_X,
        OP_Y,
        OP_H
    } t_op;

    typedef struct packed {
        logic              done;
        logic [TRIG_W-1:0] cos_mag;
        logic              cos_neg;
        logic [TRIG_W-1:0] sin_mag;
        logic              sin_neg;
    } t_trig;

    function automatic logic [HEAD_W-1:0] atan_q32(input logic [ATAN_IDX_W-1:0] idx);
        logic [HEAD_W-1:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            5'd24:   v = 32'd41;
            5'd25:   v = 32'd20;
            5'd26:   v = 32'd10;
            5'd27:   v = 32'd5;
            5'd28:   v = 32'd3;
            5'd29:   v = 32'd1;
            5'd30:   v = 32'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/planar_pose_dead_reckoning_top.sv
// Planar pose dead reckoning: forward-Euler pose update per velocity transfer.
// Depends on ppdr_pkg and ppdr_cordic.
//
// Each input transfer (linear velocity, angular velocity, step time) moves x
// and y by v*dt times cos/sin of the heading held before the update, then moves
// the heading by w*dt, and yields one result with the new pose, both velocities
// and a flag set when x or y clipped at the 48-bit limit. Pose resets to zero.
// Per item, the CORDIC runs one micro-rotation per cycle, and one 18x26
// multiplier forms all products, the wide ones in halves, and the division by
// 62500 too, as a multiply by a scaled reciprocal and a one-step remainder fix,
// in states MUL_LO, MUL_HI, DIV_INIT, RCP_LO, RCP_HI, RCP_FIX and POS_UPD for x
// and for y, and MUL_LO, MUL_HI and HEAD_UPD for the heading.
// The input is ready only in idle; a finished result waits in an output
// register while the next item is taken.
`timescale 1ns / 1ps
`default_nettype none
module planar_pose_dead_reckoning_top
    import ppdr_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [VEL_W-1:0] i_linear_velocity,
    input  logic signed [VEL_W-1:0] i_angular_velocity,
    input  logic [DT_W-1:0]         i_step_time,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [POS_W-1:0] o_pos_x,
    output logic signed [POS_W-1:0] o_pos_y,
    output logic [HEAD_W-1:0]       o_heading,
    output logic signed [VEL_W-1:0] o_speed_echo,
    output logic signed [VEL_W-1:0] o_turn_rate_echo,
    output logic                    o_saturated
);

    t_state r_state;
    t_state n_state;
    t_op    r_op;

    logic signed [VEL_W-1:0] r_v;
    logic signed [VEL_W-1:0] r_w;
    logic [DT_W-1:0]         r_dt;
    logic [MAG_W-1:0]        r_tmag;
    logic [MAG_W-1:0]        r_pmag;
    logic [TRIG_W-1:0]       r_cmag;
    logic [TRIG_W-1:0]       r_smag;
    logic                    r_cneg;
    logic                    r_sneg;
    logic [ACC_W-1:0]        r_acc;
    logic [DVD_W-1:0]        r_rem;
    logic [DIV_Q_W-1:0]      r_quo;

    logic signed [POS_W-1:0] r_pos_x;
    logic signed [POS_W-1:0] r_pos_y;
    logic [HEAD_W-1:0]       r_head;
    logic                    r_sat;

    logic                    r_ovalid;
    logic signed [POS_W-1:0] r_out_x;
    logic signed [POS_W-1:0] r_out_y;
    logic [HEAD_W-1:0]       r_out_head;
    logic signed [VEL_W-1:0] r_out_v;
    logic signed [VEL_W-1:0] r_out_w;
    logic                    r_out_sat;

    logic                    w_accept;
    logic                    w_load_out;
    t_trig                   w_trig;
    logic [VEL_W-1:0]        w_vmag;
    logic [VEL_W-1:0]        w_wmag;
    logic [MUL_A_W-1:0]      w_ma;
    logic [MUL_B_W-1:0]      w_mb;
    logic [MUL_P_W-1:0]      w_prod;
    logic [ACC_W-1:0]        w_acc_rnd;
    logic [DIV_Q_W-1:0]      w_q0;
    logic [DVD_W-1:0]        w_rcp_rem;
    logic                    w_fix;
    logic                    w_neg;
    logic signed [SUM_W-1:0] w_q;
    logic signed [SUM_W-1:0] w_delta;
    logic signed [POS_W-1:0] w_pos_cur;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [POS_W-1:0] n_pos;
    logic                    w_clip;
    logic [ACC_W-1:0]        w_h_rnd;
    logic [HEAD_W-1:0]       w_dm;
    logic [HEAD_W-1:0]       n_head;

    ppdr_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_angle (r_head),
        .o_trig  (w_trig)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state    = r_state;
        w_load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_MUL_T;
                end
            end
            S_MUL_T:    n_state = S_MUL_P;
            S_MUL_P:    n_state = S_TRIG;
            S_TRIG: begin
                if (w_trig.done) begin
                    n_state = S_MUL_LO;
                end
            end
            S_MUL_LO:   n_state = S_MUL_HI;
            S_MUL_HI:   n_state = (r_op == OP_H) ? S_HEAD_UPD : S_DIV_INIT;
            S_DIV_INIT: n_state = S_RCP_LO;
            S_RCP_LO:   n_state = S_RCP_HI;
            S_RCP_HI:   n_state = S_RCP_FIX;
            S_RCP_FIX:  n_state = S_POS_UPD;
            S_POS_UPD:  n_state = S_MUL_LO;
            S_HEAD_UPD: n_state = S_OUT;
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // shared multiplier operand select
    assign w_vmag = r_v[VEL_W-1] ? VEL_W'(-r_v) : VEL_W'(r_v);
    assign w_wmag = r_w[VEL_W-1] ? VEL_W'(-r_w) : VEL_W'(r_w);

    always_comb begin
        unique case (r_state) inside
            S_MUL_T: w_ma = MUL_A_W'(w_vmag);
            S_MUL_P: w_ma = MUL_A_W'(w_wmag);
            S_MUL_LO: w_ma = (r_op == OP_H) ? r_pmag[MUL_A_W-1:0] : r_tmag[MUL_A_W-1:0];
            S_MUL_HI: w_ma = (r_op == OP_H) ? r_pmag[MAG_W-1:MUL_A_W]
                                            : r_tmag[MAG_W-1:MUL_A_W];
            S_RCP_LO: w_ma = r_rem[MUL_A_W-1:0];
            S_RCP_HI: w_ma = MUL_A_W'(r_rem[DVD_W-1:MUL_A_W]);
            S_RCP_FIX: w_ma = DIV_D;
            default: w_ma = '0;
        endcase
        unique case (r_state) inside
            S_MUL_T, S_MUL_P: w_mb = MUL_B_W'(r_dt);
            S_MUL_LO, S_MUL_HI: begin
                case (r_op)
                    OP_X:    w_mb = r_cmag;
                    OP_Y:    w_mb = r_smag;
                    default: w_mb = ANG_SCALE;
                endcase
            end
            S_RCP_LO, S_RCP_HI: w_mb = DIV_RCP;
            S_RCP_FIX: w_mb = MUL_B_W'(w_q0);
            default: w_mb = '0;
        endcase
    end

    assign w_prod    = MUL_P_W'(w_ma) * MUL_P_W'(w_mb);
    assign w_acc_rnd = r_acc + POS_HALF;

    // reciprocal estimate is the quotient or one below it
    assign w_q0      = r_acc[RCP_FRAC +: DIV_Q_W];
    assign w_rcp_rem = r_rem - DVD_W'(w_prod);
    assign w_fix     = (w_rcp_rem >= DVD_W'(DIV_D));

    // position step: signed quotient, add, clamp to 48 bits
    assign w_neg     = r_v[VEL_W-1] ^ ((r_op == OP_X) ? r_cneg : r_sneg);
    assign w_q       = signed'(SUM_W'(r_quo));
    assign w_delta   = w_neg ? -w_q : w_q;
    assign w_pos_cur = (r_op == OP_X) ? r_pos_x : r_pos_y;
    assign w_sum     = signed'({w_pos_cur[POS_W-1], w_pos_cur}) + w_delta;

    always_comb begin
        w_clip = 1'b0;
        n_pos  = w_sum[POS_W-1:0];
        if (w_sum > POS_MAX_EXT) begin
            w_clip = 1'b1;
            n_pos  = POS_MAX_EXT[POS_W-1:0];
        end else if (w_sum < POS_MIN_EXT) begin
            w_clip = 1'b1;
            n_pos  = POS_MIN_EXT[POS_W-1:0];
        end
    end

    // heading step: round the scaled angle, wrap modulo 2^32
    assign w_h_rnd = r_acc + ANG_HALF;
    assign w_dm    = w_h_rnd[ANG_FRAC +: HEAD_W];
    assign n_head  = r_w[VEL_W-1] ? (r_head - w_dm) : (r_head + w_dm);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_X;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_head   <= '0;
            r_sat    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_sat <= 1'b0;
            end
            if (r_state == S_TRIG && w_trig.done) begin
                r_op <= OP_X;
            end
            if (r_state == S_POS_UPD) begin
                if (r_op == OP_X) begin
                    r_pos_x <= n_pos;
                    r_op    <= OP_Y;
                end else begin
                    r_pos_y <= n_pos;
                    r_op    <= OP_H;
                end
                if (w_clip) begin
                    r_sat <= 1'b1;
                end
            end
            if (r_state == S_HEAD_UPD) begin
                r_head <= n_head;
            end
            if (w_load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_v  <= i_linear_velocity;
            r_w  <= i_angular_velocity;
            r_dt <= i_step_time;
        end
        case (r_state) inside
            S_MUL_T: r_tmag <= MAG_W'(w_prod);
            S_MUL_P: r_pmag <= MAG_W'(w_prod);
            S_TRIG: begin
                if (w_trig.done) begin
                    r_cmag <= w_trig.cos_mag;
                    r_cneg <= w_trig.cos_neg;
                    r_smag <= w_trig.sin_mag;
                    r_sneg <= w_trig.sin_neg;
                end
            end
            S_MUL_LO, S_RCP_LO: r_acc <= ACC_W'(w_prod);
            S_MUL_HI, S_RCP_HI: r_acc <= r_acc + (ACC_W'(w_prod) << MUL_A_W);
            S_DIV_INIT: r_rem <= DVD_W'(w_acc_rnd >> (POS_FRAC + RCP_SH));
            S_RCP_FIX:  r_quo <= w_q0 + DIV_Q_W'(w_fix);
            default: ;
        endcase
        if (w_load_out) begin
            r_out_x    <= r_pos_x;
            r_out_y    <= r_pos_y;
            r_out_head <= r_head;
            r_out_v    <= r_v;
            r_out_w    <= r_w;
            r_out_sat  <= r_sat;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_pos_x          = r_out_x;
    assign o_pos_y          = r_out_y;
    assign o_heading        = r_out_head;
    assign o_speed_echo     = r_out_v;
    assign o_turn_rate_echo = r_out_w;
    assign o_saturated      = r_out_sat;

`ifndef SYNTHESIS
    a_rcp_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RCP_FIX) |-> (w_rcp_rem < (DVD_W'(DIV_D) << 1)))
        else $error("reciprocal quotient estimate off by more than one");

    a_quo_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POS_UPD) |-> !r_quo[DIV_Q_W-1])
        else $error("position step quotient overflow");

    a_head_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_HEAD_UPD) |=> $stable(r_head))
        else $error("heading changed outside its update step");
`endif

endmodule
`default_nettype wire

### rtl/ppdr_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per cycle, giving cos and sin of a
// binary angle as Q24 magnitude and sign. Depends on ppdr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ppdr_cordic
    import ppdr_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [HEAD_W-1:0] i_angle,
    output t_trig             o_trig
);

    localparam int CW = $clog2(CORDIC_STEPS);
    localparam logic [CW-1:0] LAST = CW'(CORDIC_STEPS - 1);

    logic                     r_busy;
    logic                     r_done;
    logic                     r_flip;
    logic [CW-1:0]            r_cnt;
    logic signed [CORD_W-1:0] r_x;
    logic signed [CORD_W-1:0] r_y;
    logic signed [CORD_W-1:0] r_z;

    logic signed [CORD_W-1:0] w_a;
    logic signed [CORD_W-1:0] w_z0;
    logic                     w_flip0;
    logic signed [CORD_W-1:0] w_xs;
    logic signed [CORD_W-1:0] w_ys;
    logic signed [CORD_W-1:0] w_at;
    logic [CORD_W-1:0]        w_xm;
    logic [CORD_W-1:0]        w_ym;

    // fold the angle into [-pi/2, pi/2]
    always_comb begin
        w_a = {{(CORD_W - HEAD_W){i_angle[HEAD_W-1]}}, i_angle};
        w_flip0 = 1'b0;
        w_z0 = w_a;
        if (w_a > QUARTER_TURN) begin
            w_z0 = w_a - HALF_TURN;
            w_flip0 = 1'b1;
        end else if (w_a < -QUARTER_TURN) begin
            w_z0 = w_a + HALF_TURN;
            w_flip0 = 1'b1;
        end
    end

    assign w_xs = r_x >>> r_cnt;
    assign w_ys = r_y >>> r_cnt;
    assign w_at = signed'(CORD_W'(atan_q32(ATAN_IDX_W'(r_cnt))));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= w_z0;
            r_flip <= w_flip0;
        end else if (r_busy) begin
            if (!r_z[CORD_W-1]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end
        end
    end

    // round Q30 to Q24, half away from zero, on the magnitude
    assign w_xm = r_x[CORD_W-1] ? CORD_W'(-r_x) : CORD_W'(r_x);
    assign w_ym = r_y[CORD_W-1] ? CORD_W'(-r_y) : CORD_W'(r_y);

    assign o_trig.done    = r_done;
    assign o_trig.cos_mag = TRIG_W'((w_xm + CORD_W'(32)) >> ROUND_SH);
    assign o_trig.cos_neg = r_x[CORD_W-1] ^ r_flip;
    assign o_trig.sin_mag = TRIG_W'((w_ym + CORD_W'(32)) >> ROUND_SH);
    assign o_trig.sin_neg = r_y[CORD_W-1] ^ r_flip;

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Testbench for planar_pose_dead_reckoning_top: velocity and step-time transfers in, pose out.
// A local fixed-point CORDIC and Euler-step model predicts every result.
// Depends on ppdr_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_top;
    import ppdr_pkg::*;

    localparam int ROT_STEPS    = CORDIC_STEPS_DEF;
    localparam int QUIET_LIMIT  = 6000;
    localparam int DRAIN_CYCLES = ROT_STEPS + 80;
    localparam int HOLD_CYCLES  = 900;

    localparam longint POS_TOP = 64'sd140737488355327;
    localparam longint POS_BOT = -POS_TOP - 64'sd1;
    localparam longint QTR_ANG = 64'sd1073741824;
    localparam longint HALF_ANG = 64'sd2147483648;
    localparam longint ROT_GAIN = 64'sd652032874;
    localparam longint unsigned POS_DEN = 64'd62500 << 24;
    localparam longint unsigned TURN_GAIN = 64'd44798134;

    localparam logic signed [VEL_W-1:0] VEL_MAX = 16'sh7fff;
    localparam logic signed [VEL_W-1:0] VEL_MIN = 16'sh8000;
    localparam logic [DT_W-1:0] DT_MAX = 20'hfffff;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic [HEAD_W-1:0]        heading;
        logic signed [VEL_W-1:0]  speed_echo;
        logic signed [VEL_W-1:0]  turn_rate_echo;
        logic                     saturated;
    } pose_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic signed [VEL_W-1:0] i_linear_velocity = '0;
    logic signed [VEL_W-1:0] i_angular_velocity = '0;
    logic [DT_W-1:0]         i_step_time = '0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic signed [POS_W-1:0] o_pos_x;
    logic signed [POS_W-1:0] o_pos_y;
    logic [HEAD_W-1:0]       o_heading;
    logic signed [VEL_W-1:0] o_speed_echo;
    logic signed [VEL_W-1:0] o_turn_rate_echo;
    logic                    o_saturated;

    longint rot_angle [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    longint        x_pos = 0;
    longint        y_pos = 0;
    logic [31:0]   head_ang = '0;
    pose_t         pose_due [$];
    pose_t         want_pose;

    int  errors = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  wraps_seen = 0;
    int  quiet = 0;
    int  hold_req = 0;
    int  hold_left = 0;
    int  stall_left = 0;
    bit  src_gaps = 1'b0;
    bit  sink_gaps = 1'b0;

    planar_pose_dead_reckoning_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_linear_velocity  (i_linear_velocity),
        .i_angular_velocity (i_angular_velocity),
        .i_step_time        (i_step_time),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_pos_x            (o_pos_x),
        .o_pos_y            (o_pos_y),
        .o_heading          (o_heading),
        .o_speed_echo       (o_speed_echo),
        .o_turn_rate_echo   (o_turn_rate_echo),
        .o_saturated        (o_saturated)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint unsigned magnitude(input longint a);
        return (a < 0) ? -a : a;
    endfunction

    function automatic longint q30_to_q24(input longint a);
        longint unsigned m;
        m = (magnitude(a) + 64'd32) >> 6;
        return (a < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint scaled_step(input longint t, input longint c);
        longint unsigned m;
        longint unsigned q;
        m = magnitude(t) * magnitude(c);
        q = (m + POS_DEN / 2) / POS_DEN;
        return ((t < 0) != (c < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic pose_t advance_pose(input logic signed [VEL_W-1:0] v,
            input logic signed [VEL_W-1:0] w, input logic [DT_W-1:0] dt);
        longint ang, cx, cy, xs, ys, cos_q, sin_q, t, p, nx, ny;
        longint unsigned dm;
        logic [32:0] head_sum;
        bit flip, sat;
        pose_t r;
        ang = longint'($signed(head_ang));
        flip = 1'b0;
        sat = 1'b0;
        if (ang > QTR_ANG) begin
            ang = ang - HALF_ANG;
            flip = 1'b1;
        end else if (ang < -QTR_ANG) begin
            ang = ang + HALF_ANG;
            flip = 1'b1;
        end
        cx = ROT_GAIN;
        cy = 0;
        for (int i = 0; i < ROT_STEPS; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (ang >= 0) begin
                cx = cx - ys;
                cy = cy + xs;
                ang = ang - rot_angle[i];
            end else begin
                cx = cx + ys;
                cy = cy - xs;
                ang = ang + rot_angle[i];
            end
        end
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end
        cos_q = q30_to_q24(cx);
        sin_q = q30_to_q24(cy);

        t = longint'(v) * longint'(dt);
        nx = x_pos + scaled_step(t, cos_q);
        ny = y_pos + scaled_step(t, sin_q);
        if (nx > POS_TOP) begin
            nx = POS_TOP;
            sat = 1'b1;
        end else if (nx < POS_BOT) begin
            nx = POS_BOT;
            sat = 1'b1;
        end
        if (ny > POS_TOP) begin
            ny = POS_TOP;
            sat = 1'b1;
        end else if (ny < POS_BOT) begin
            ny = POS_BOT;
            sat = 1'b1;
        end
        x_pos = nx;
        y_pos = ny;

        p = longint'(w) * longint'(dt);
        dm = (magnitude(p) * TURN_GAIN + (64'd1 << 27)) >> 28;
        if (p < 0) begin
            head_sum = {1'b0, head_ang} - {1'b0, dm[31:0]};
        end else begin
            head_sum = {1'b0, head_ang} + {1'b0, dm[31:0]};
        end
        if (head_sum[32] || dm[63:32] != 0) begin
            wraps_seen++;
        end
        head_ang = head_sum[31:0];

        r.pos_x          = nx[POS_W-1:0];
        r.pos_y          = ny[POS_W-1:0];
        r.heading        = head_ang;
        r.speed_echo     = v;
        r.turn_rate_echo = w;
        r.saturated      = sat;
        return r;
    endfunction

    task automatic send_sample(input logic signed [VEL_W-1:0] v,
            input logic signed [VEL_W-1:0] w, input logic [DT_W-1:0] dt);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_linear_velocity  <= v;
        i_angular_velocity <= w;
        i_step_time        <= dt;
        do @(posedge i_clk); while (!o_ready);
        pose_due.push_back(advance_pose(v, w, dt));
        items_sent++;
    endtask

    function automatic logic signed [VEL_W-1:0] pick_vel();
        case ($urandom_range(0, 9))
            0:       return VEL_MAX;
            1:       return VEL_MIN;
            2:       return '0;
            default: return VEL_W'($urandom);
        endcase
    endfunction

    function automatic logic [DT_W-1:0] pick_dt();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DT_MAX;
            2, 3:    return DT_W'($urandom_range(1, 2000));
            default: return DT_W'($urandom_range(0, 1048575));
        endcase
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] want,
            input logic signed [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pose_due.size() == 0) begin
                $error("pose transfer with none expected: pos_x %0d", o_pos_x);
                errors++;
            end else begin
                want_pose = pose_due.pop_front();
                check_field("pos_x", want_pose.pos_x, o_pos_x);
                check_field("pos_y", want_pose.pos_y, o_pos_y);
                check_field("heading", want_pose.heading, o_heading);
                check_field("speed_echo", want_pose.speed_echo, o_speed_echo);
                check_field("turn_rate_echo", want_pose.turn_rate_echo, o_turn_rate_echo);
                check_field("saturated", want_pose.saturated, o_saturated);
                results_seen++;
            end
        end
    end

    initial begin : sink_side
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 18);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // Pose must hold when the step time is zero, whatever the velocities.
    task automatic test_zero_step();
        send_sample(VEL_MAX, VEL_MAX, '0);
        send_sample(VEL_MIN, VEL_MIN, '0);
        send_sample('0, '0, '0);
    endtask

    task automatic test_straight_extremes();
        send_sample(VEL_MAX, '0, DT_MAX);
        send_sample(VEL_MIN, '0, DT_MAX);
        send_sample(16'sd1, '0, 20'd1);
        send_sample(-16'sd1, '0, 20'd1);
        send_sample('0, '0, DT_MAX);
        send_sample(VEL_MAX, '0, 20'd1);
    endtask

    // Full-scale turns push the heading past a whole revolution in one step.
    task automatic test_turn_wrap();
        send_sample('0, VEL_MAX, DT_MAX);
        send_sample('0, VEL_MIN, DT_MAX);
        send_sample(VEL_MAX, VEL_MAX, DT_MAX);
        send_sample(VEL_MAX, VEL_MAX, DT_MAX);
        send_sample(VEL_MAX, VEL_MAX, DT_MAX);
        send_sample(VEL_MIN, VEL_MIN, DT_MAX);
        send_sample(VEL_MIN, VEL_MIN, DT_MAX);
        send_sample(16'sd1, 16'sd1, 20'd1);
        send_sample(-16'sd1, -16'sd1, 20'd1);
    endtask

    // Roughly quarter-turn steps walk the heading through every quadrant.
    task automatic test_quadrant_sweep();
        for (int k = 0; k < 5; k++) begin
            send_sample(16'sd20000, VEL_MAX, 20'd196350);
        end
    endtask

    task automatic test_output_backpressure();
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        hold_req = HOLD_CYCLES;
        for (int k = 0; k < 10; k++) begin
            send_sample(pick_vel(), pick_vel(), pick_dt());
        end
    endtask

    task automatic test_random_mix();
        for (int k = 0; k < 1350; k++) begin
            if (k % 90 == 0) begin
                src_gaps = $urandom_range(0, 2) != 0;
                sink_gaps = $urandom_range(0, 2) != 0;
            end
            send_sample(pick_vel(), pick_vel(), pick_dt());
        end
    endtask

    task automatic test_random_steady();
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        for (int k = 0; k < 320; k++) begin
            send_sample(pick_vel(), pick_vel(), pick_dt());
        end
    endtask

    initial begin : run
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_step();
        test_straight_extremes();
        test_turn_wrap();
        test_quadrant_sweep();
        test_output_backpressure();
        test_random_mix();
        test_random_steady();
        i_valid <= 1'b0;
        while (pose_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("tb_top: %0d velocity transfers sent, %0d pose transfers checked",
                 items_sent, results_seen);
        $display("tb_top: %0d heading wraps, one %0d-cycle output hold, random idling",
                 wraps_seen, HOLD_CYCLES);
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
